// ===== rtl/satq_pkg.sv =====
// Shared types and constants for the sorted alarm timer queue.
// Used by the queue cell and the top level; depends on nothing else.
`timescale 1ns / 1ps

package satq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int TIME_W  = 32;
	localparam int DELAY_W = 16;
	localparam int TAG_W   = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Input item selector carried on tuser.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Result kind carried on tuser.
	localparam logic KIND_FIRED  = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] deadline;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// Command broadcast to every cell of the row at once.
	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [TIME_W-1:0] due;
		logic [TAG_W-1:0]  tag;
	} cmd_t;

endpackage

// ===== rtl/satq_cell.sv =====
// One cell of the sorted row: holds a single deadline and tag.
// Depends on satq_pkg for the entry and command types.
`timescale 1ns / 1ps

module satq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  satq_pkg::cmd_t  cmd,
	input  logic            left_keep,
	input  satq_pkg::entry_t left_ent,
	input  satq_pkg::entry_t right_ent,
	output satq_pkg::entry_t ent,
	output logic            keep
);

	satq_pkg::entry_t ent_q;
	satq_pkg::entry_t ent_d;
	logic             load;

	// An entry stays put on insert when it is due no later than the new one,
	// so equal deadlines remain first in, first out.
	assign keep = ent_q.valid && (ent_q.deadline <= cmd.due);

	always_comb begin
		ent_d = ent_q;
		load  = 1'b0;
		if (cmd.ins && !keep) begin
			load = 1'b1;
			if (left_keep) begin
				ent_d.valid    = 1'b1;
				ent_d.deadline = cmd.due;
				ent_d.tag      = cmd.tag;
			end else begin
				ent_d = left_ent;
			end
		end else if (cmd.pop) begin
			load  = 1'b1;
			ent_d = right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (load) begin
			ent_q <= ent_d;
		end
	end

	assign ent = ent_q;

endmodule

// ===== rtl/sorted_alarm_timer_queue_top.sv =====
// Top level of the sorted alarm timer queue: time counter, control and output register.
// Depends on satq_pkg and instantiates a row of satq_cell.
`timescale 1ns / 1ps

// Alarms are held in a row of DEPTH cells kept in deadline order, head first. On an insert item
// (tuser 0) every cell compares its deadline with the new one and either holds, takes the new
// alarm or takes its left neighbour, so the row stays sorted; a full row instead returns one
// rejected result. A tick item (tuser 1) advances the saturating time counter and then fires the
// due alarms from the head, one per cycle while the output is not stalled, as the row shifts left,
// the final one marked with tlast. No new item is taken until the tick has fired all due alarms,
// and a stalled output holds it longer.

module sorted_alarm_timer_queue_top #(
	parameter int DEPTH = satq_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // delay [15:0], tag [31:16]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // alarm_tag [15:0], due_time [47:16]
	output logic        m_tuser,   // kind
	output logic        m_tlast
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                          state_q;
	logic [satq_pkg::TIME_W-1:0]   time_q;
	logic                          m_valid_q;
	logic [47:0]                   m_data_q;
	logic                          m_user_q;
	logic                          m_last_q;

	satq_pkg::entry_t ents [DEPTH];
	logic             keeps[DEPTH];
	satq_pkg::cmd_t   cmd;

	logic [satq_pkg::DELAY_W-1:0]  in_delay;
	logic [satq_pkg::TAG_W-1:0]    in_tag;
	logic [satq_pkg::TIME_W:0]     sum;
	logic [satq_pkg::TIME_W-1:0]   due;
	logic                          out_free;
	logic                          accept;
	logic                          full;
	logic                          head_due;
	logic                          next_due;
	logic                          do_pop;
	logic                          do_reject;

	assign in_delay = s_tdata[15:0];
	assign in_tag   = s_tdata[31:16];

	assign sum = {1'b0, time_q} + {{(satq_pkg::TIME_W + 1 - satq_pkg::DELAY_W){1'b0}}, in_delay};
	assign due = sum[satq_pkg::TIME_W] ? satq_pkg::TIME_MAX : sum[satq_pkg::TIME_W-1:0];

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = ents[DEPTH-1].valid;

	assign head_due = ents[0].valid && (ents[0].deadline <= time_q);
	assign next_due = ents[1].valid && (ents[1].deadline <= time_q);
	assign do_pop   = (state_q == ST_DRAIN) && head_due && out_free;
	assign do_reject = accept && (s_tuser == satq_pkg::FUNC_INSERT) && full;

	always_comb begin
		cmd.ins = accept && (s_tuser == satq_pkg::FUNC_INSERT) && !full;
		cmd.pop = do_pop;
		cmd.due = due;
		cmd.tag = in_tag;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		satq_pkg::entry_t left_ent;
		satq_pkg::entry_t right_ent;
		logic             left_keep;

		if (i == 0) begin : g_head
			assign left_ent  = '0;
			assign left_keep = 1'b1;
		end else begin : g_body
			assign left_ent  = ents[i-1];
			assign left_keep = keeps[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ents[i+1];
		end

		satq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_keep (left_keep),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.ent       (ents[i]),
			.keep      (keeps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			time_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (do_pop || do_reject) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == satq_pkg::FUNC_TICK)) begin
						if (time_q != satq_pkg::TIME_MAX) begin
							time_q <= time_q + 1'b1;
						end
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Leave once nothing is due, or after the final due alarm has gone out.
					if (!head_due || (do_pop && !next_due)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_reject) begin
			m_data_q <= {due, in_tag};
			m_user_q <= satq_pkg::KIND_REJECT;
			m_last_q <= 1'b1;
		end else if (do_pop) begin
			m_data_q <= {ents[0].deadline, ents[0].tag};
			m_user_q <= satq_pkg::KIND_FIRED;
			m_last_q <= !next_due;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== test/alarm_queue_checker.sv =====
// Checker for the sorted alarm timer queue: watches both stream channels, predicts every result
// from the accepted items and compares it with what the block returns. Depends on satq_pkg.
`timescale 1ns / 1ps

module alarm_queue_checker #(
	parameter int DEPTH = satq_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // delay [15:0], tag [31:16]
	input  logic        s_tuser,   // func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // alarm_tag [15:0], due_time [47:16]
	input  logic        m_tuser,   // kind
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic                        kind;
		logic [satq_pkg::TAG_W-1:0]  alarm_tag;
		logic [satq_pkg::TIME_W-1:0] due_time;
		logic                        last;
	} alarm_result_t;

	// Private copy of the queue contents, head at index 0.
	logic [satq_pkg::TIME_W-1:0] clock_now;
	logic [satq_pkg::TIME_W-1:0] due_at [DEPTH];
	logic [satq_pkg::TAG_W-1:0]  tag_at [DEPTH];
	int                          held;

	alarm_result_t awaited_alarms [$];
	alarm_result_t oldest;
	int            mismatches;

	task automatic predict_alarm_item(input logic func,
			input logic [satq_pkg::DELAY_W-1:0] delay, input logic [satq_pkg::TAG_W-1:0] tag);
		logic [satq_pkg::TIME_W:0]   sum;
		logic [satq_pkg::TIME_W-1:0] due;
		alarm_result_t               r;
		int                          pos;
		int                          fired;
		int                          i;
		if (func == satq_pkg::FUNC_INSERT) begin
			sum = {1'b0, clock_now}
				+ {{(satq_pkg::TIME_W + 1 - satq_pkg::DELAY_W){1'b0}}, delay};
			due = sum[satq_pkg::TIME_W] ? satq_pkg::TIME_MAX : sum[satq_pkg::TIME_W-1:0];
			if (held >= DEPTH) begin
				r.kind      = satq_pkg::KIND_REJECT;
				r.alarm_tag = tag;
				r.due_time  = due;
				r.last      = 1'b1;
				awaited_alarms.push_back(r);
			end else begin
				// Equal deadlines go behind the ones already held.
				pos = 0;
				while (pos < held && due_at[pos] <= due)
					pos++;
				for (i = held; i > pos; i--) begin
					due_at[i] = due_at[i-1];
					tag_at[i] = tag_at[i-1];
				end
				due_at[pos] = due;
				tag_at[pos] = tag;
				held++;
			end
		end else begin
			if (clock_now != satq_pkg::TIME_MAX)
				clock_now++;
			fired = 0;
			while (fired < held && due_at[fired] <= clock_now) begin
				r.kind      = satq_pkg::KIND_FIRED;
				r.alarm_tag = tag_at[fired];
				r.due_time  = due_at[fired];
				r.last      = (fired + 1 == held) || (due_at[fired+1] > clock_now);
				awaited_alarms.push_back(r);
				fired++;
			end
			for (i = 0; i + fired < held; i++) begin
				due_at[i] = due_at[i+fired];
				tag_at[i] = tag_at[i+fired];
			end
			held = held - fired;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_now = '0;
			held = 0;
			mismatches = 0;
			awaited_alarms.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Results are checked before the new item is predicted: a result accepted at this
			// edge always belongs to an item accepted earlier.
			if (m_tvalid && m_tready) begin
				if (awaited_alarms.size() == 0) begin
					$error("result with none expected: kind %0d tag %h due %h last %0d",
						m_tuser, m_tdata[15:0], m_tdata[47:16], m_tlast);
					mismatches++;
				end else begin
					oldest = awaited_alarms.pop_front();
					if (m_tuser !== oldest.kind) begin
						$error("kind: expected %0d, got %0d", oldest.kind, m_tuser);
						mismatches++;
					end
					if (m_tdata[15:0] !== oldest.alarm_tag) begin
						$error("alarm_tag: expected %h, got %h", oldest.alarm_tag,
							m_tdata[15:0]);
						mismatches++;
					end
					if (m_tdata[47:16] !== oldest.due_time) begin
						$error("due_time: expected %h, got %h", oldest.due_time,
							m_tdata[47:16]);
						mismatches++;
					end
					if (m_tlast !== oldest.last) begin
						$error("last: expected %0d, got %0d", oldest.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_alarm_item(s_tuser, s_tdata[15:0], s_tdata[31:16]);
			fail_count <= mismatches;
			pending <= awaited_alarms.size();
		end
	end

endmodule

// ===== test/sorted_alarm_timer_queue_top_tb.sv =====
// Testbench top for the sorted alarm timer queue: clock, reset, insert and tick stimulus with
// random stalls on both channels, and the verdict. Depends on satq_pkg and alarm_queue_checker.
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_top_tb;

	localparam int QUEUE_DEPTH  = satq_pkg::DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 145;
	localparam int CALM_FROM    = 115;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // delay [15:0], tag [31:16]
	logic        s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // alarm_tag [15:0], due_time [47:16]
	logic        m_tuser;   // kind
	logic        m_tlast;
	int          fail_count;
	int          pending;
	logic        calm;

	sorted_alarm_timer_queue_top #(
		.DEPTH(QUEUE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	alarm_queue_checker #(
		.DEPTH(QUEUE_DEPTH)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Output side: random stall bursts until the calm tail of the run.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Leaves tvalid high on return, so back-to-back items need no second assignment.
	task automatic send_alarm_item(input logic func, input logic [15:0] delay,
			input logic [15:0] tag);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {tag, delay};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Mostly short delays so alarms fire often; now and then a long one that stays queued.
	function automatic logic [15:0] pick_delay();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 16'($urandom_range(0, 8));
		else if (roll < 94)
			return 16'($urandom_range(0, 40));
		else if (roll < 98)
			return 16'($urandom_range(0, 65535));
		else
			return 16'hFFFF;
	endfunction

	initial begin
		int k;
		calm     = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= satq_pkg::FUNC_INSERT;
		s_tdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick on an empty queue fires nothing.
		send_alarm_item(satq_pkg::FUNC_TICK, 16'h0000, 16'h0000);
		// Fill the queue with alarms due now or one tick later; equal deadlines keep their order.
		for (k = 0; k < QUEUE_DEPTH; k++)
			send_alarm_item(satq_pkg::FUNC_INSERT, 16'(k % 2), 16'(k * 16'h1111));
		// Full queue: this one comes back rejected.
		send_alarm_item(satq_pkg::FUNC_INSERT, 16'hFFFF, 16'hA5A5);
		// Next tick empties the whole queue in one burst.
		send_alarm_item(satq_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF);
		// The longest delay, which outlives the run.
		send_alarm_item(satq_pkg::FUNC_INSERT, 16'hFFFF, 16'h5A5A);
		send_alarm_item(satq_pkg::FUNC_INSERT, 16'h0003, 16'h1234);
		send_alarm_item(satq_pkg::FUNC_INSERT, 16'h0003, 16'h4321);
		repeat (3) send_alarm_item(satq_pkg::FUNC_TICK, 16'h0000, 16'h0000);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k >= CALM_FROM)
				calm = 1'b1;
			if ($urandom_range(0, 99) < 45)
				send_alarm_item(satq_pkg::FUNC_TICK, 16'($urandom), 16'($urandom));
			else
				send_alarm_item(satq_pkg::FUNC_INSERT, pick_delay(), 16'($urandom));
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
